### sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg: cartridge bank controller decoder shared definitions
// Payload structs for the bus access and decode result channels, region,
// status and controller kind codes.
// ----------------------------------------------------------------------------
package cbc_pkg;

   typedef struct packed {
      logic        cmd;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  region;
      logic [20:0] local_address;
      logic        nibble_only;
      logic        store_write;
      logic [7:0]  store_data;
      logic [2:0]  status;
   } rsp_payload_type;

   // access kind
   localparam logic CMD_WRITE = 1'b1;

   // decode regions
   localparam logic [4:0] REGION_BOOT       = 5'd0;
   localparam logic [4:0] REGION_ROM        = 5'd1;
   localparam logic [4:0] REGION_VRAM       = 5'd2;
   localparam logic [4:0] REGION_EXTRAM     = 5'd3;
   localparam logic [4:0] REGION_CLOCK_REG  = 5'd4;
   localparam logic [4:0] REGION_WRAM       = 5'd5;
   localparam logic [4:0] REGION_OAM        = 5'd6;
   localparam logic [4:0] REGION_UNUSABLE   = 5'd7;
   localparam logic [4:0] REGION_VIDEO_IO   = 5'd8;
   localparam logic [4:0] REGION_ZEROPAGE   = 5'd9;
   localparam logic [4:0] REGION_INT_ENABLE = 5'd10;
   localparam logic [4:0] REGION_INT_FLAGS  = 5'd11;
   localparam logic [4:0] REGION_TIMER      = 5'd12;
   localparam logic [4:0] REGION_JOYPAD     = 5'd13;
   localparam logic [4:0] REGION_SOUND      = 5'd14;
   localparam logic [4:0] REGION_WAVE_RAM   = 5'd15;
   localparam logic [4:0] REGION_UNMAPPED   = 5'd16;
   localparam logic [4:0] REGION_BANK_CTRL  = 5'd17;

   // result status
   localparam logic [2:0] STATUS_OK             = 3'd0;
   localparam logic [2:0] STATUS_EXTRAM_OFF     = 3'd1;
   localparam logic [2:0] STATUS_MBC2_ADDR_BIT  = 3'd2;
   localparam logic [2:0] STATUS_MBC2_RAM_LIMIT = 3'd3;
   localparam logic [2:0] STATUS_MBC3_SELECTOR  = 3'd4;
   localparam logic [2:0] STATUS_BOOT_BLOCKED   = 3'd5;

   // controller kinds
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_MBC1  = 3'd1;
   localparam logic [2:0] KIND_MBC2  = 3'd2;
   localparam logic [2:0] KIND_MBC3  = 3'd3;
   localparam logic [2:0] KIND_OTHER = 3'd4;

   // control register indexes
   localparam logic [1:0] CSR_CONTROLLER_KIND = 2'd0;
   localparam logic [1:0] CSR_RAM_SIZE_CODE   = 2'd1;

   // ram size code that selects four banked pages
   localparam logic [2:0] RAM_SIZE_BANKED = 3'd3;

endpackage

### sv/cartridge_bank_controller_decoder_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_decoder_core: cartridge bus decoder and banking
// Decodes one 16-bit bus access per transfer into a region and local offset
// and keeps the MBC1/MBC2/MBC3 bank registers and the boot overlay flag.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | flow
//   --------+--------------------------------+-----------+----------------------
//   req     | req_valid req_stall req_payload| in        | one bus access
//   rsp     | rsp_valid rsp_stall rsp_payload| out       | one decode result
//   csr     | csr_valid csr_ready csr_index  | in        | controller kind and
//           | csr_wdata                      |           | ram size code writes
//
// the access is decoded from the input register and lands in the result register,
// which drives rsp valid and rsp payload, so its rsp transfer follows its req
// transfer; a new access each cycle while rsp is not stalled
// bank register updates commit as an access moves into the result register,
// so the next access already decodes with them
// reset is synchronous and active high; it empties both registers and loads
// the bank state (boot overlay on, extram on, rom page 1)
// a stall on rsp holds the result register and backs up into req_stall once
// the input register is also occupied
//
module cartridge_bank_controller_decoder_core (
   input  logic                     clock,
   input  logic                     reset,
   // access channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cbc_pkg::req_payload_type req_payload,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cbc_pkg::rsp_payload_type rsp_payload,
   // control register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [2:0]               csr_wdata
);

   // mbc1 bank zero quirk: a page with low five bits zero selects the next one
   function automatic logic [6:0] mbc1_fix(input logic [6:0] p);
      logic [6:0] r;
      r = p;
      if (p[4:0] == 5'd0) begin
         r[0] = 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   logic [2:0] kind_ff, kind_in;
   logic [2:0] ram_size_ff, ram_size_in;

   assign csr_ready = 1'b1;

   always_comb begin
      kind_in     = kind_ff;
      ram_size_in = ram_size_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == cbc_pkg::CSR_CONTROLLER_KIND) begin
            kind_in = csr_wdata;
         end else if (csr_index == cbc_pkg::CSR_RAM_SIZE_CODE) begin
            ram_size_in = csr_wdata;
         end
      end
   end

   // ---------------------------------------------------------------------
   // handshake: input register feeds result register
   // ---------------------------------------------------------------------
   logic                     in_valid_ff, in_valid_in;
   cbc_pkg::req_payload_type in_data_ff, in_data_in;
   logic                     out_valid_ff, out_valid_in;
   cbc_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                     advance;
   logic                     req_accept;

   // the result register is free when empty or being drained this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign in_data_in   = req_accept ? req_payload : in_data_ff;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // ---------------------------------------------------------------------
   // bank state
   // ---------------------------------------------------------------------
   logic       boot_ff, boot_in;
   logic       extram_en_ff, extram_en_in;
   logic       bank_mode_ff, bank_mode_in;
   logic [1:0] ram_page_ff, ram_page_in;
   logic [6:0] rom_page_ff, rom_page_in;
   logic [3:0] clock_sel_ff, clock_sel_in;

   // ---------------------------------------------------------------------
   // decode of the access in the input register
   // ---------------------------------------------------------------------
   cbc_pkg::rsp_payload_type res;
   logic [2:0]  kind;
   logic        wr;
   logic [15:0] a;
   logic [7:0]  b;
   logic [7:0]  sdata;
   logic        st;
   logic [6:0]  page;
   logic [6:0]  page_m1;
   logic [6:0] rom_nx;
   logic [1:0] ram_nx;
   logic [3:0] clk_nx;
   logic       boot_nx, ext_nx, mode_nx;

   always_comb begin
      kind    = (kind_ff > cbc_pkg::KIND_OTHER) ? cbc_pkg::KIND_OTHER : kind_ff;
      wr      = (in_data_ff.cmd == cbc_pkg::CMD_WRITE);
      a       = in_data_ff.bus_address;
      b       = in_data_ff.write_data;
      sdata   = b;
      st      = 1'b0;
      page    = (rom_page_ff == 7'd0) ? 7'd1 : rom_page_ff;
      page_m1 = page - 7'd1;
      rom_nx  = rom_page_ff;
      ram_nx  = ram_page_ff;
      clk_nx  = clock_sel_ff;
      boot_nx = boot_ff;
      ext_nx  = extram_en_ff;
      mode_nx = bank_mode_ff;

      res.region        = cbc_pkg::REGION_UNMAPPED;
      res.local_address = 21'd0;
      res.nibble_only   = 1'b0;
      res.store_write   = 1'b0;
      res.store_data    = 8'd0;
      res.status        = cbc_pkg::STATUS_OK;

      if (a < 16'h8000) begin
         // rom space: reads, kind none rom writes, or bank control writes
         if (!wr) begin
            res.region        = cbc_pkg::REGION_ROM;
            res.local_address = {5'd0, a};
            if (a < 16'h1000 && boot_ff) begin
               if (a < 16'h0100) begin
                  res.region = cbc_pkg::REGION_BOOT;
               end else if (a == 16'h0100) begin
                  boot_nx = 1'b0;
               end
            end else if (a >= 16'h4000 && kind != cbc_pkg::KIND_NONE) begin
               res.local_address = {page_m1, 14'd0} + {6'd0, a[14:0]};
            end
         end else if (a < 16'h2000 && kind == cbc_pkg::KIND_NONE) begin
            res.local_address = {5'd0, a};
            if (boot_ff && a < 16'h0100) begin
               res.region = cbc_pkg::REGION_BOOT;
               res.status = cbc_pkg::STATUS_BOOT_BLOCKED;
            end else begin
               if (boot_ff && a == 16'h0100) begin
                  boot_nx = 1'b0;
               end
               res.region = cbc_pkg::REGION_ROM;
               st         = 1'b1;
            end
         end else if (kind == cbc_pkg::KIND_MBC1 || kind == cbc_pkg::KIND_MBC2 ||
                      kind == cbc_pkg::KIND_MBC3) begin
            res.region        = cbc_pkg::REGION_BANK_CTRL;
            res.local_address = {5'd0, a};
            unique case (a[14:13])
               2'd0: begin
                  // ram enable
                  if (kind == cbc_pkg::KIND_MBC2 && a[8]) begin
                     res.status = cbc_pkg::STATUS_MBC2_ADDR_BIT;
                  end else begin
                     ext_nx = (b[3:0] == 4'hA);
                  end
               end
               2'd1: begin
                  // rom bank low bits
                  if (kind == cbc_pkg::KIND_MBC1) begin
                     rom_nx = mbc1_fix({rom_page_ff[6:5], b[4:0]});
                  end else if (kind == cbc_pkg::KIND_MBC2) begin
                     if (!a[8]) begin
                        res.status = cbc_pkg::STATUS_MBC2_ADDR_BIT;
                     end else begin
                        rom_nx = (b[3:0] == 4'd0) ? 7'd1 : {3'd0, b[3:0]};
                     end
                  end else begin
                     rom_nx = (b[6:0] == 7'd0) ? 7'd1 : b[6:0];
                  end
               end
               2'd2: begin
                  // ram bank, upper rom bits, or mbc3 clock select
                  if (kind == cbc_pkg::KIND_MBC1) begin
                     if (bank_mode_ff) begin
                        ram_nx = b[1:0];
                     end else begin
                        rom_nx = mbc1_fix({b[1:0], rom_page_ff[4:0]});
                     end
                  end else if (kind == cbc_pkg::KIND_MBC3) begin
                     if (b <= 8'd3) begin
                        ram_nx = b[1:0];
                        clk_nx = 4'd0;
                     end else if (b >= 8'd8 && b <= 8'h0C) begin
                        clk_nx = b[3:0];
                     end else begin
                        res.status = cbc_pkg::STATUS_MBC3_SELECTOR;
                     end
                  end
               end
               default: begin
                  // banking mode select
                  if (kind == cbc_pkg::KIND_MBC1) begin
                     mode_nx = b[0];
                  end
               end
            endcase
         end
      end else if (a < 16'hA000) begin
         res.region        = cbc_pkg::REGION_VRAM;
         res.local_address = {8'd0, a[12:0]};
         st                = wr;
      end else if (a < 16'hC000) begin
         // external ram or mbc3 clock registers
         res.region        = cbc_pkg::REGION_EXTRAM;
         res.local_address = {8'd0, a[12:0]};
         if (kind == cbc_pkg::KIND_MBC1 ||
             (kind == cbc_pkg::KIND_MBC3 && clock_sel_ff == 4'd0)) begin
            if (ram_size_ff == cbc_pkg::RAM_SIZE_BANKED) begin
               res.local_address = {6'd0, ram_page_ff, a[12:0]};
            end
         end else if (kind == cbc_pkg::KIND_MBC3) begin
            res.region        = cbc_pkg::REGION_CLOCK_REG;
            res.local_address = {18'd0, clock_sel_ff[2:0]};
         end else if (kind == cbc_pkg::KIND_MBC2) begin
            if (a > 16'hA1FF) begin
               res.region        = cbc_pkg::REGION_UNMAPPED;
               res.local_address = 21'd0;
            end else begin
               res.nibble_only = 1'b1;
               sdata           = {4'd0, b[3:0]};
            end
         end else if (kind == cbc_pkg::KIND_OTHER) begin
            res.region        = cbc_pkg::REGION_UNMAPPED;
            res.local_address = 21'd0;
         end
         if (kind == cbc_pkg::KIND_MBC2 && a > 16'hA1FF) begin
            res.status = cbc_pkg::STATUS_MBC2_RAM_LIMIT;
         end else begin
            if (!extram_en_ff) begin
               res.status = cbc_pkg::STATUS_EXTRAM_OFF;
            end
            st = wr && (res.region != cbc_pkg::REGION_UNMAPPED);
         end
      end else begin
         // work ram, oam and the i/o page
         st = wr;
         if (a < 16'hFE00) begin
            res.region        = cbc_pkg::REGION_WRAM;
            res.local_address = {8'd0, a[12:0]};
         end else if (a < 16'hFEA0) begin
            res.region        = cbc_pkg::REGION_OAM;
            res.local_address = {13'd0, a[7:0]};
         end else if (a < 16'hFF00) begin
            res.region = cbc_pkg::REGION_UNUSABLE;
            st         = 1'b0;
         end else if (a == 16'hFFFF) begin
            res.region = cbc_pkg::REGION_INT_ENABLE;
         end else if (a >= 16'hFF80) begin
            res.region        = cbc_pkg::REGION_ZEROPAGE;
            res.local_address = {14'd0, a[6:0]};
         end else if (a >= 16'hFF40) begin
            res.region        = cbc_pkg::REGION_VIDEO_IO;
            res.local_address = {15'd0, a[5:0]};
         end else if (a == 16'hFF0F) begin
            res.region = cbc_pkg::REGION_INT_FLAGS;
         end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
            res.region        = cbc_pkg::REGION_TIMER;
            res.local_address = {19'd0, a[1:0]};
            if (a == 16'hFF04) begin
               // divider reset
               sdata = 8'd0;
            end
         end else if (a == 16'hFF00) begin
            res.region = cbc_pkg::REGION_JOYPAD;
            sdata      = {2'd0, b[5:4], 4'd0};
         end else if (wr && a >= 16'hFF10 && a <= 16'hFF26) begin
            res.region        = cbc_pkg::REGION_SOUND;
            res.local_address = {16'd0, a[4:0] - 5'h10};
         end else if (wr && a >= 16'hFF30 && a <= 16'hFF3F) begin
            res.region        = cbc_pkg::REGION_WAVE_RAM;
            res.local_address = {17'd0, a[3:0]};
         end else begin
            res.region = cbc_pkg::REGION_UNMAPPED;
            st         = 1'b0;
         end
      end

      res.store_write = st;
      res.store_data  = st ? sdata : 8'd0;
   end

   assign out_data_in = advance ? res : out_data_ff;

   // state commits only when the access moves into the result register
   assign boot_in      = advance ? boot_nx : boot_ff;
   assign extram_en_in = advance ? ext_nx  : extram_en_ff;
   assign bank_mode_in = advance ? mode_nx : bank_mode_ff;
   assign ram_page_in  = advance ? ram_nx  : ram_page_ff;
   assign rom_page_in  = advance ? rom_nx  : rom_page_ff;
   assign clock_sel_in = advance ? clk_nx  : clock_sel_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         kind_ff      <= cbc_pkg::KIND_NONE;
         ram_size_ff  <= 3'd0;
         boot_ff      <= 1'b1;
         extram_en_ff <= 1'b1;
         bank_mode_ff <= 1'b0;
         ram_page_ff  <= 2'd0;
         rom_page_ff  <= 7'd1;
         clock_sel_ff <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         kind_ff      <= kind_in;
         ram_size_ff  <= ram_size_in;
         boot_ff      <= boot_in;
         extram_en_ff <= extram_en_in;
         bank_mode_ff <= bank_mode_in;
         ram_page_ff  <= ram_page_in;
         rom_page_ff  <= rom_page_in;
         clock_sel_ff <= clock_sel_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // the rom bank register never holds zero
   assert property (@(posedge clock) disable iff (reset) rom_page_ff != 7'd0)
      else $error("rom page register holds zero");

   // req is only stalled while the input register holds an access
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("req stalled with empty input register");

   // a result that drains with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && !advance) |=> !rsp_valid)
      else $error("result repeated after transfer");

   // nibble-only results always target external ram
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.nibble_only) |->
         (rsp_payload.region == cbc_pkg::REGION_EXTRAM))
      else $error("nibble flag outside external ram");

endmodule
